// ----- rtl/uart_8n1_transceiver_unit_macros.svh -----
// Assertion helpers for the UART transceiver. Every check is clocked on clk and
// is switched off while arst_n is low.
`ifndef UART_8N1_TRANSCEIVER_UNIT_MACROS_SVH
`define UART_8N1_TRANSCEIVER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UART8_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UART8_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/uart8_pkg.sv -----
package uart8_pkg;

	localparam int TIMER_WIDTH = 16;
	localparam int CFG_W = 16;
	localparam int PERIOD_W = TIMER_WIDTH + 1;
	localparam int CMP_W = ((PERIOD_W > CFG_W) ? PERIOD_W : CFG_W) + 1;
	localparam logic [CFG_W-1:0] CYCLES_PER_BIT_RESET = CFG_W'(260);

	// Transmit bit positions: start, eight data bits, stop.
	localparam logic [3:0] TX_IDX_START = 4'd0;
	localparam logic [3:0] TX_IDX_LAST_DATA = 4'd8;
	localparam logic [3:0] TX_IDX_STOP = 4'd9;

	typedef enum logic [1:0] {
		RX_IDLE = 2'd0,
		RX_DATA = 2'd1,
		RX_STOP = 2'd2
	} rx_phase_t;

	typedef struct packed {
		logic tx_level;
		logic send_busy;
	} tx_res_t;

	typedef struct packed {
		logic [7:0] received_byte;
		logic received_valid;
	} rx_res_t;

	typedef struct packed {
		logic tx_level;
		logic send_busy;
		logic [7:0] received_byte;
		logic received_valid;
	} result_t;

	// Bit period in ticks of the bit clock: zero counts as one, and the period never
	// exceeds the range of the bit timers.
	function automatic logic [PERIOD_W-1:0] bit_period(input logic [CFG_W-1:0] cfg);
		logic [CMP_W-1:0] wide;
		logic [CMP_W-1:0] limit;
		wide = CMP_W'(cfg);
		limit = CMP_W'(1) << TIMER_WIDTH;
		if (wide == '0) begin
			wide = CMP_W'(1);
		end
		if (wide > limit) begin
			wide = limit;
		end
		return wide[PERIOD_W-1:0];
	endfunction

endpackage

// ----- rtl/uart8_in_if.sv -----
interface uart8_in_if;
	logic valid;
	logic ready;
	logic rx_level;
	logic send_request;
	logic [7:0] send_byte;

	modport source (output valid, output rx_level, output send_request, output send_byte,
		input ready);
	modport sink (input valid, input rx_level, input send_request, input send_byte,
		output ready);
endinterface

// ----- rtl/uart8_out_if.sv -----
interface uart8_out_if;
	logic valid;
	logic ready;
	logic tx_level;
	logic send_busy;
	logic [7:0] received_byte;
	logic received_valid;

	modport source (output valid, output tx_level, output send_busy, output received_byte,
		output received_valid, input ready);
	modport sink (input valid, input tx_level, input send_busy, input received_byte,
		input received_valid, output ready);
endinterface

// ----- rtl/uart_8n1_transceiver_unit.sv -----
// Full-duplex 8N1 UART. Each transfer on item_in is one tick of the bit clock:
// it carries the sampled receive line level and an optional send request with
// its byte. Each tick yields exactly one transfer on result_out with the
// transmit line level, the busy flag, the receive shift register and a
// one-tick received-byte strobe.
// cfg_we/cfg_wdata load cycles_per_bit, the bit period in ticks.
// A tick accepted into the input register is processed into the output
// queue when the queue has room, and its result is then offered from there.
// Throughput is one tick per clock cycle while results are taken; a single
// register stage sits in front of the transmit and receive timers.
// Reset: cycles_per_bit is 260, the transmitter is idle with the line high,
// the receiver waits for a start bit, and both shift registers are clear.
// When the result consumer stalls, up to two results wait in the output
// queue and one tick waits in the input register; item_in.ready then drops
// until a result transfer frees a slot. Timer state only advances as ticks
// move forward, so stalls never change the outcome.
`include "uart_8n1_transceiver_unit_macros.svh"

module uart_8n1_transceiver_unit (
	input  logic clk,
	input  logic arst_n,
	uart8_in_if.sink item_in,
	uart8_out_if.source result_out,
	input  logic cfg_we,
	input  logic [uart8_pkg::CFG_W-1:0] cfg_wdata
);

	logic [uart8_pkg::CFG_W-1:0] cycles_per_bit_q;
	logic [uart8_pkg::PERIOD_W-1:0] period;

	logic v_s1;
	logic rx_level_s1;
	logic send_request_s1;
	logic [7:0] send_byte_s1;

	logic accept;
	logic advance;
	logic room;
	logic [1:0] q_count;

	uart8_pkg::tx_res_t tx_res;
	uart8_pkg::rx_res_t rx_res;
	uart8_pkg::result_t res;
	uart8_pkg::result_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycles_per_bit_q <= uart8_pkg::CYCLES_PER_BIT_RESET;
		end else if (cfg_we) begin
			cycles_per_bit_q <= cfg_wdata;
		end
	end

	assign period = uart8_pkg::bit_period(cycles_per_bit_q);

	assign advance = v_s1 && room;
	assign item_in.ready = !v_s1 || advance;
	assign accept = item_in.valid && item_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item_in.ready) begin
			v_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rx_level_s1 <= item_in.rx_level;
			send_request_s1 <= item_in.send_request;
			send_byte_s1 <= item_in.send_byte;
		end
	end

	uart8_tx u_tx (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.period(period),
		.send_request(send_request_s1),
		.send_byte(send_byte_s1),
		.res(tx_res)
	);

	uart8_rx u_rx (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.period(period),
		.rx_level(rx_level_s1),
		.res(rx_res)
	);

	always_comb begin
		res.tx_level = tx_res.tx_level;
		res.send_busy = tx_res.send_busy;
		res.received_byte = rx_res.received_byte;
		res.received_valid = rx_res.received_valid;
	end

	uart8_obuf u_obuf (
		.clk(clk),
		.arst_n(arst_n),
		.push(advance),
		.din(res),
		.room(room),
		.out_valid(result_out.valid),
		.out_ready(result_out.ready),
		.dout(head),
		.count(q_count)
	);

	assign result_out.tx_level = head.tx_level;
	assign result_out.send_busy = head.send_busy;
	assign result_out.received_byte = head.received_byte;
	assign result_out.received_valid = head.received_valid;

	`UART8_ASSERT_SAME(a_queue_bound, 1'b1, q_count != 2'd3, "output queue overfilled")
	`UART8_ASSERT_SAME(a_idle_line_high, advance && !res.send_busy, res.tx_level,
		"transmit line low while transmitter idle")
	`UART8_ASSERT_NEXT(a_stall_holds, v_s1 && !room, v_s1, "stalled tick dropped")
	`UART8_ASSERT_NEXT(a_push_visible, advance, result_out.valid,
		"pushed result not offered")

endmodule

// ----- rtl/uart8_tx.sv -----
module uart8_tx (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic [uart8_pkg::PERIOD_W-1:0] period,
	input  logic send_request,
	input  logic [7:0] send_byte,
	output uart8_pkg::tx_res_t res
);

	logic [7:0] shift_q, shift_n;
	logic [3:0] idx_q, idx_n;
	logic [uart8_pkg::TIMER_WIDTH-1:0] timer_q, timer_n;
	logic active_q, active_n;

	logic start;
	logic [7:0] eff_shift;
	logic [3:0] eff_idx;
	logic [uart8_pkg::TIMER_WIDTH-1:0] eff_timer;
	logic [uart8_pkg::PERIOD_W-1:0] tsum;
	logic [3:0] data_pos;

	always_comb begin
		start = !active_q && send_request;
		eff_shift = start ? send_byte : shift_q;
		eff_idx = start ? uart8_pkg::TX_IDX_START : idx_q;
		eff_timer = start ? '0 : timer_q;
		tsum = {1'b0, eff_timer} + uart8_pkg::PERIOD_W'(1);
		data_pos = eff_idx - 4'd1;

		shift_n = shift_q;
		idx_n = idx_q;
		timer_n = timer_q;
		active_n = active_q;
		res.tx_level = 1'b1;
		res.send_busy = 1'b0;

		if (active_q || send_request) begin
			res.send_busy = 1'b1;
			active_n = 1'b1;
			shift_n = eff_shift;
			if (eff_idx == uart8_pkg::TX_IDX_START) begin
				res.tx_level = 1'b0;
			end else if (eff_idx <= uart8_pkg::TX_IDX_LAST_DATA) begin
				res.tx_level = eff_shift[data_pos[2:0]];
			end
			if (tsum >= period) begin
				timer_n = '0;
				if (eff_idx >= uart8_pkg::TX_IDX_STOP) begin
					idx_n = uart8_pkg::TX_IDX_START;
					active_n = 1'b0;
				end else begin
					idx_n = eff_idx + 4'd1;
				end
			end else begin
				timer_n = tsum[uart8_pkg::TIMER_WIDTH-1:0];
				idx_n = eff_idx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			idx_q <= '0;
			timer_q <= '0;
			active_q <= 1'b0;
		end else if (step) begin
			shift_q <= shift_n;
			idx_q <= idx_n;
			timer_q <= timer_n;
			active_q <= active_n;
		end
	end

endmodule

// ----- rtl/uart8_rx.sv -----
module uart8_rx (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic [uart8_pkg::PERIOD_W-1:0] period,
	input  logic rx_level,
	output uart8_pkg::rx_res_t res
);

	uart8_pkg::rx_phase_t phase_q, phase_n;
	logic [uart8_pkg::PERIOD_W-1:0] timer_q, timer_n;
	logic [2:0] idx_q, idx_n;
	logic [7:0] shift_q, shift_n;

	logic [uart8_pkg::PERIOD_W:0] rsum;
	logic [uart8_pkg::PERIOD_W:0] target;

	always_comb begin
		rsum = {1'b0, timer_q} + (uart8_pkg::PERIOD_W + 1)'(1);
		// The first sample lands in the middle of bit 0, one and a half periods
		// after the falling edge of the start bit.
		if (idx_q == 3'd0) begin
			target = {1'b0, period} + {2'b00, period[uart8_pkg::PERIOD_W-1:1]};
		end else begin
			target = {1'b0, period};
		end

		phase_n = phase_q;
		timer_n = timer_q;
		idx_n = idx_q;
		shift_n = shift_q;
		res.received_valid = 1'b0;

		case (phase_q)
			uart8_pkg::RX_DATA: begin
				if (rsum >= target) begin
					timer_n = '0;
					shift_n = {rx_level, shift_q[7:1]};
					if (idx_q == 3'd7) begin
						idx_n = 3'd0;
						phase_n = uart8_pkg::RX_STOP;
					end else begin
						idx_n = idx_q + 3'd1;
					end
				end else begin
					timer_n = rsum[uart8_pkg::PERIOD_W-1:0];
				end
			end
			uart8_pkg::RX_STOP: begin
				if (rsum >= {1'b0, period}) begin
					timer_n = '0;
					res.received_valid = 1'b1;
					phase_n = uart8_pkg::RX_IDLE;
				end else begin
					timer_n = rsum[uart8_pkg::PERIOD_W-1:0];
				end
			end
			default: begin
				phase_n = uart8_pkg::RX_IDLE;
				if (!rx_level) begin
					phase_n = uart8_pkg::RX_DATA;
					timer_n = '0;
					idx_n = 3'd0;
				end
			end
		endcase

		res.received_byte = shift_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= uart8_pkg::RX_IDLE;
			timer_q <= '0;
			idx_q <= '0;
			shift_q <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			timer_q <= timer_n;
			idx_q <= idx_n;
			shift_q <= shift_n;
		end
	end

endmodule

// ----- rtl/uart8_obuf.sv -----
module uart8_obuf (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  uart8_pkg::result_t din,
	output logic room,
	output logic out_valid,
	input  logic out_ready,
	output uart8_pkg::result_t dout,
	output logic [1:0] count
);

	uart8_pkg::result_t mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic pop;

	assign out_valid = (count_q != 2'd0);
	assign pop = out_valid && out_ready;
	// A slot frees up in the same cycle the head transfer completes.
	assign room = (count_q != 2'd2) || pop;
	assign dout = mem_q[rd_ptr_q];
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
